FILE: hdl/bfa_pkg.sv
// Shared constants and ctrl/datapath interface types for the best-fit unit allocator.
// No dependencies.
package bfa_pkg;

    localparam int UNIT_BITS   = 10;
    localparam int UNITS       = 1 << UNIT_BITS;
    localparam int CNT_BITS    = UNIT_BITS + 1;
    localparam int OWNER_BITS  = 8;
    localparam int ID_BITS     = 8;
    localparam int START_BITS  = 10;
    localparam int LEN_BITS    = 11;
    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   clr;
        logic                   scan;
        logic                   fit;
        logic                   fill;
        logic                   free;
        logic                   post;
        logic [STATUS_BITS-1:0] code;
    } bfa_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic bad;
        logic mode_free;
        logic free_none;
        logic scan_done;
        logic found;
        logic fill_last;
        logic free_done;
        logic out_free;
    } bfa_sts_t;

endpackage

FILE: hdl/bfa_datapath.sv
// Datapath: owner map memory, address counters, run tracking and result register.
// Depends on bfa_pkg.
module bfa_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bfa_pkg::bfa_cmd_t           cmd,
    output bfa_pkg::bfa_sts_t           sts,
    input  logic                        in_mode,
    input  logic [bfa_pkg::ID_BITS-1:0]    in_owner,
    input  logic [bfa_pkg::START_BITS-1:0] in_start,
    input  logic [bfa_pkg::LEN_BITS-1:0]   in_length,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bfa_pkg::STATUS_BITS-1:0] out_status,
    output logic [bfa_pkg::START_BITS-1:0]  out_start
);
    import bfa_pkg::*;

    logic [OWNER_BITS-1:0] mem [UNITS];
    logic [OWNER_BITS-1:0] rdata_reg;

    logic                  mode_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [CNT_BITS-1:0]   len_reg;
    logic                  bad_reg;
    logic                  free_none_reg;

    logic [CNT_BITS-1:0]   addr_reg;
    logic [CNT_BITS-1:0]   end_reg;
    logic                  rd_valid_reg;
    logic [CNT_BITS-1:0]   rd_idx_reg;

    logic [UNIT_BITS-1:0]  run_start_reg;
    logic [CNT_BITS-1:0]   run_len_reg;
    logic [UNIT_BITS-1:0]  best_start_reg;
    logic [CNT_BITS-1:0]   best_size_reg;
    logic                  found_reg;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [START_BITS-1:0]  out_start_reg;

    logic [LEN_BITS:0]      in_end;
    logic [CNT_BITS-1:0]    in_end_clip;
    logic                   issue;
    logic                   is_free;
    logic                   run_fits;
    logic                   mem_we;
    logic [UNIT_BITS-1:0]   mem_waddr;
    logic [OWNER_BITS-1:0]  mem_wdata;

    always_comb
    begin
        in_end = (LEN_BITS+1)'(in_start) + (LEN_BITS+1)'(in_length);
        if (in_end > (LEN_BITS+1)'(UNITS))
        begin
            in_end_clip = CNT_BITS'(UNITS);
        end
        else
        begin
            in_end_clip = CNT_BITS'(in_end);
        end
    end

    assign issue = (cmd.scan && (addr_reg <= CNT_BITS'(UNITS))) ||
                   (cmd.free && (addr_reg < end_reg));
    assign is_free  = (rd_idx_reg < CNT_BITS'(UNITS)) && (rdata_reg == '0);
    assign run_fits = (run_len_reg >= len_reg) && (!found_reg || (run_len_reg < best_size_reg));

    // single write port: clearing pass, fill, or free of a matching unit
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg[UNIT_BITS-1:0];
        mem_wdata = '0;
        if (cmd.clr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.fill)
        begin
            mem_we    = 1'b1;
            mem_wdata = owner_reg;
        end
        else if (cmd.free && rd_valid_reg && (rdata_reg == owner_reg))
        begin
            mem_we    = 1'b1;
            mem_waddr = rd_idx_reg[UNIT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg[UNIT_BITS-1:0]];
    end

    // request capture, run tracking, read index and result capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= in_mode;
            owner_reg     <= OWNER_BITS'(in_owner);
            len_reg       <= CNT_BITS'(in_length);
            bad_reg       <= (OWNER_BITS'(in_owner) == '0) || (in_length == '0) ||
                             (in_length > LEN_BITS'(UNITS));
            free_none_reg <= (CNT_BITS'(in_start) >= CNT_BITS'(UNITS));
            end_reg       <= in_end_clip;
        end
        else if (cmd.fit)
        begin
            end_reg <= CNT_BITS'(best_start_reg) + len_reg;
        end

        if (cmd.load)
        begin
            run_len_reg   <= '0;
            best_start_reg <= '0;
            best_size_reg <= '0;
        end
        else if (cmd.scan && rd_valid_reg)
        begin
            if (is_free)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_reg <= rd_idx_reg[UNIT_BITS-1:0];
                end
                run_len_reg <= run_len_reg + 1'b1;
            end
            else if (run_len_reg != '0)
            begin
                if (run_fits)
                begin
                    best_start_reg <= run_start_reg;
                    best_size_reg  <= run_len_reg;
                end
                run_len_reg <= '0;
            end
        end

        rd_idx_reg <= addr_reg;

        if (cmd.post)
        begin
            out_status_reg <= cmd.code;
            out_start_reg  <= ((cmd.code == ST_DONE) && !mode_reg) ?
                              START_BITS'(best_start_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                addr_reg <= in_mode ? CNT_BITS'(in_start) : '0;
            end
            else if (cmd.fit)
            begin
                addr_reg <= CNT_BITS'(best_start_reg);
            end
            else if (cmd.clr || cmd.fill || issue)
            begin
                addr_reg <= addr_reg + 1'b1;
            end

            rd_valid_reg <= issue && !cmd.load;

            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan && rd_valid_reg && !is_free && (run_len_reg != '0) && run_fits)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.post)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.clr_last  = (addr_reg == CNT_BITS'(UNITS - 1));
        sts.bad       = bad_reg;
        sts.mode_free = mode_reg;
        sts.free_none = free_none_reg;
        sts.scan_done = rd_valid_reg && (rd_idx_reg == CNT_BITS'(UNITS));
        sts.found     = found_reg;
        sts.fill_last = ((addr_reg + 1'b1) == end_reg);
        sts.free_done = rd_valid_reg && ((rd_idx_reg + 1'b1) == end_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;

endmodule

FILE: hdl/bfa_ctrl.sv
// Controller state machine: sequences clearing, scan, fill, free and result posting.
// Depends on bfa_pkg.
module bfa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfa_pkg::bfa_sts_t  sts,
    output bfa_pkg::bfa_cmd_t  cmd
);
    import bfa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FIT   = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_FREE  = 3'd6;
    localparam logic [2:0] S_POST  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [STATUS_BITS-1:0] code_reg, code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (sts.bad)
                begin
                    code_next  = ST_BAD;
                    state_next = S_POST;
                end
                else if (sts.mode_free && sts.free_none)
                begin
                    code_next  = ST_DONE;
                    state_next = S_POST;
                end
                else if (sts.mode_free)
                begin
                    state_next = S_FREE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                if (sts.found)
                begin
                    cmd.fit    = 1'b1;
                    state_next = S_FILL;
                end
                else
                begin
                    code_next  = ST_NOFIT;
                    state_next = S_POST;
                end
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    code_next  = ST_DONE;
                    state_next = S_POST;
                end
            end
            S_FREE:
            begin
                cmd.free = 1'b1;
                if (sts.free_done)
                begin
                    code_next  = ST_DONE;
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                // wait for the result register to drain
                if (sts.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

FILE: hdl/best_fit_unit_allocator_core.sv
// Best-fit unit allocator: owner map of UNITS tags with one request in flight at a time.
// Allocate takes one pass over the map plus a fill of each granted unit; free walks each unit
// in the clipped range. Every request also passes through acceptance, decode and result posting,
// and takes longer while a result waits on m_axis_tready. The map lives in a memory with one
// write port and one registered read port, with one write and one registered read each cycle.
// After reset a clearing pass zeroes the map; requests are not taken until it ends. The result
// register lets the next request start while the previous result is still waiting on
// m_axis_tready.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath.
module best_fit_unit_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // owner_id[7:0], start_unit[17:8], length[28:18]
    input  logic [0:0]  s_axis_tuser,  // mode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // alloc_start[9:0]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);
    import bfa_pkg::*;

    bfa_cmd_t               cmd;
    bfa_sts_t               sts;
    logic [START_BITS-1:0]  alloc_start;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_axis_tuser[0]),
        .in_owner   (s_axis_tdata[7:0]),
        .in_start   (s_axis_tdata[17:8]),
        .in_length  (s_axis_tdata[28:18]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_start  (alloc_start)
    );

    assign m_axis_tdata = {{(16-START_BITS){1'b0}}, alloc_start};

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result posted over an unread result");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata == '0))
        else $error("nonzero start on a failed request");

    a_mem_users: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr, cmd.scan, cmd.fill, cmd.free}))
        else $error("memory claimed by more than one operation");
`endif

endmodule

FILE: sim/bfa_checker.sv
// Scoreboard for the best-fit unit allocator: watches both stream channels, predicts each result
// from its own copy of the owner map and compares it with what the block returns.
// Depends on bfa_pkg.
module bfa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // owner_id[7:0], start_unit[17:8], length[28:18]
    input  logic [0:0]  s_axis_tuser,  // mode[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,  // alloc_start[9:0]
    input  logic [1:0]  m_axis_tuser,  // status[1:0]
    output int          errors,
    output int          outstanding
);
    import bfa_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [START_BITS-1:0]  alloc_start;
    } alloc_result_t;

    logic [OWNER_BITS-1:0] unit_owner [UNITS];
    alloc_result_t         expected_results [$];

    // Applies one request to the local owner map and returns the answer the block must give.
    function automatic alloc_result_t serve_request(
        input logic                  mode_free,
        input logic [ID_BITS-1:0]    owner_id,
        input logic [START_BITS-1:0] start_unit,
        input logic [LEN_BITS-1:0]   length
    );
        logic [OWNER_BITS-1:0] tag;
        alloc_result_t         res;
        int                    last;
        int                    run_start;
        int                    run_len;
        int                    best_start;
        int                    best_size;
        bit                    found;
        bit                    is_free;
        tag             = owner_id[OWNER_BITS-1:0];
        res.status      = ST_DONE;
        res.alloc_start = '0;
        if (tag == '0 || length == '0 || int'(length) > UNITS)
        begin
            res.status = ST_BAD;
            return res;
        end
        if (mode_free)
        begin
            // range clipped at the top of memory; other owners' units stay put
            last = int'(start_unit) + int'(length);
            if (last > UNITS)
                last = UNITS;
            for (int u = int'(start_unit); u < last; u++)
                if (unit_owner[u] == tag)
                    unit_owner[u] = '0;
            return res;
        end
        found      = 0;
        best_start = 0;
        best_size  = 0;
        run_start  = 0;
        run_len    = 0;
        // maximal free runs only; strict < keeps the lowest start on a size tie
        for (int u = 0; u <= UNITS; u++)
        begin
            is_free = (u < UNITS) && (unit_owner[u] == '0);
            if (is_free)
            begin
                if (run_len == 0)
                    run_start = u;
                run_len++;
            end
            else if (run_len != 0)
            begin
                if (run_len >= int'(length) && (!found || run_len < best_size))
                begin
                    found      = 1;
                    best_start = run_start;
                    best_size  = run_len;
                end
                run_len = 0;
            end
        end
        if (!found)
        begin
            res.status = ST_NOFIT;
            return res;
        end
        for (int u = best_start; u < best_start + int'(length); u++)
            unit_owner[u] = tag;
        res.alloc_start = START_BITS'(best_start);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        int            n_err;
        n_err = 0;
        if (!rst_n)
        begin
            for (int u = 0; u < UNITS; u++)
                unit_owner[u] = '0;
            expected_results.delete();
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(serve_request(s_axis_tuser[0], s_axis_tdata[7:0],
                                                         s_axis_tdata[17:8],
                                                         s_axis_tdata[28:18]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: status=%0d alloc_start=%0d",
                           m_axis_tuser, m_axis_tdata[9:0]);
                    n_err++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        n_err++;
                    end
                    if (m_axis_tdata[9:0] != want.alloc_start)
                    begin
                        $error("alloc_start: expected %0d, got %0d", want.alloc_start,
                               m_axis_tdata[9:0]);
                        n_err++;
                    end
                end
            end
            errors      <= errors + n_err;
            outstanding <= expected_results.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top for best_fit_unit_allocator_core: drives allocate/free requests through several
// backpressure phases and gives the verdict. Depends on bfa_pkg, the core and bfa_checker.
module tb;
    import bfa_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int LIMIT_CYCLES = 2_500_000;
    localparam int HOLD_CYCLES  = 6000;
    localparam int DRAIN_CYCLES = 64;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum int {PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_HOLD} phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int     errors;
    int     outstanding;
    phase_t phase = PH_FLOW;
    int     hold_left = 0;
    bit     held = 0;

    best_fit_unit_allocator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bfa_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    // result side; the hold phase parks tready for a long stretch once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            held          <= 0;
        end
        else if (phase == PH_HOLD && !held)
        begin
            held          <= 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (phase)
                PH_RECV_STALL: m_axis_tready <= ($urandom_range(99) >= 54);
                PH_BOTH:       m_axis_tready <= ($urandom_range(99) >= 8);
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic request(input logic mode, input logic [ID_BITS-1:0] owner_id,
                           input logic [START_BITS-1:0] start_unit,
                           input logic [LEN_BITS-1:0] length);
        int  idle_pct;
        bit  took;
        idle_pct = (phase == PH_SEND_IDLE) ? 54 : (phase == PH_BOTH) ? 8 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, length, start_unit, owner_id};
        s_axis_tuser  <= mode;
        // ready is sampled mid-cycle so the edge ordering cannot matter
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    function automatic logic [ID_BITS-1:0] pick_owner();
        if ($urandom_range(99) < 85)
            return ID_BITS'($urandom_range(1, 12));
        return ID_BITS'($urandom_range(1, 255));
    endfunction

    task automatic random_request();
        int                  r;
        logic [ID_BITS-1:0]  owner_id;
        logic [LEN_BITS-1:0] length;
        r        = $urandom_range(99);
        owner_id = pick_owner();
        if (r < 8)
        begin
            // malformed: zero owner, zero length or oversize length
            case ($urandom_range(2))
                0: request(1'($urandom), '0, START_BITS'($urandom),
                           LEN_BITS'($urandom_range(1, UNITS)));
                1: request(1'($urandom), owner_id, START_BITS'($urandom), '0);
                default: request(1'($urandom), owner_id, START_BITS'($urandom),
                                 LEN_BITS'($urandom_range(UNITS + 1, 2047)));
            endcase
        end
        else if (r < 55)
        begin
            r = $urandom_range(99);
            if (r < 80)
                length = LEN_BITS'($urandom_range(1, 48));
            else if (r < 95)
                length = LEN_BITS'($urandom_range(49, 400));
            else
                length = LEN_BITS'($urandom_range(401, UNITS));
            request(MODE_ALLOC, owner_id, START_BITS'($urandom), length);
        end
        else if (r < 95)
        begin
            if ($urandom_range(99) < 80)
                length = LEN_BITS'($urandom_range(1, 200));
            else
                length = LEN_BITS'($urandom_range(1, UNITS));
            request(MODE_FREE, owner_id, START_BITS'($urandom), length);
        end
        else
            request(MODE_FREE, owner_id, '0, LEN_BITS'(UNITS));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // malformed requests in both modes
        request(MODE_ALLOC, 8'd0,   10'd0,    11'd5);
        request(MODE_FREE,  8'd0,   10'd0,    11'd5);
        request(MODE_ALLOC, 8'd1,   10'd0,    11'd0);
        request(MODE_FREE,  8'd1,   10'd3,    11'd0);
        request(MODE_ALLOC, 8'd1,   10'd1023, 11'd1025);
        request(MODE_FREE,  8'd1,   10'd0,    11'd2047);
        // whole memory as one run, then nothing left
        request(MODE_ALLOC, 8'd255, 10'd1023, 11'd1024);
        request(MODE_ALLOC, 8'd1,   10'd0,    11'd1);
        // wrong owner frees nothing; range past the end is clipped
        request(MODE_FREE,  8'd7,   10'd0,    11'd1024);
        request(MODE_FREE,  8'd255, 10'd1000, 11'd1024);
        request(MODE_ALLOC, 8'd3,   10'd0,    11'd24);
        request(MODE_FREE,  8'd255, 10'd0,    11'd1024);
        // fragment, then check the fit choice and the tie rule
        request(MODE_ALLOC, 8'd10,  10'd0,    11'd100);
        request(MODE_ALLOC, 8'd11,  10'd0,    11'd50);
        request(MODE_ALLOC, 8'd12,  10'd0,    11'd200);
        request(MODE_ALLOC, 8'd13,  10'd0,    11'd10);
        request(MODE_FREE,  8'd11,  10'd100,  11'd50);
        request(MODE_FREE,  8'd13,  10'd350,  11'd10);
        request(MODE_ALLOC, 8'd14,  10'd0,    11'd40);
        request(MODE_ALLOC, 8'd15,  10'd0,    11'd10);
        request(MODE_FREE,  8'd14,  10'd100,  11'd40);
        request(MODE_FREE,  8'd12,  10'd150,  11'd40);
        request(MODE_ALLOC, 8'd20,  10'd0,    11'd40);

        phase = PH_FLOW;
        repeat (62) random_request();
        phase = PH_SEND_IDLE;
        repeat (62) random_request();
        phase = PH_RECV_STALL;
        repeat (62) random_request();
        phase = PH_HOLD;
        repeat (12) request(MODE_ALLOC, pick_owner(), START_BITS'($urandom),
                            LEN_BITS'($urandom_range(1, 16)));
        phase = PH_BOTH;
        repeat (62) random_request();
        s_axis_tvalid <= 1'b0;
        phase = PH_FLOW;

        // let the count of the last request settle before waiting on it
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
